// ===== rtl/dptr_pkg.sv =====
// ----------------------------------------------------------------------------
// dptr_pkg: shared types and constants of the double precision twister rng
// controller/datapath command and status bundles, register codes, defaults
// ----------------------------------------------------------------------------
package dptr_pkg;

	// default generator geometry
	localparam int POOL_ENTRIES_DEF = 191;
	localparam int LEFT_SHIFT_DEF   = 19;
	localparam int PICK_OFFSET_DEF  = 117;

	// fixed field widths
	localparam int WORD_W      = 64;
	localparam int ENTRY_W     = 2 * WORD_W;
	localparam int CFG_INDEX_W = 2;

	// seeding chain
	localparam logic [63:0] SEED_MULT   = 64'h5851_F42D_4C95_7F2D;
	localparam int          CHAIN_SHIFT = 62;
	localparam int          TEMPER_SHIFT = 12;
	localparam int          LUNG_ROT    = 32;

	// register reset values
	localparam logic [63:0] MASK_LO_RST   = 64'h000F_FAFF_FFFF_FB3F;
	localparam logic [63:0] MASK_HI_RST   = 64'h000F_FDFF_FC90_FFFD;
	localparam logic [63:0] MANT_MASK_RST = 64'h000F_FFFF_FFFF_FFFF;
	localparam logic [63:0] EXP_BITS_RST  = 64'h3FF0_0000_0000_0000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MASK_LO   = 2'd0,
		CFG_MASK_HI   = 2'd1,
		CFG_MANT_MASK = 2'd2,
		CFG_EXP_BITS  = 2'd3
	} cfg_reg_t;

	// which partial product of the 64x64 low-half multiply
	typedef enum logic [1:0] {
		MUL_LO_LO,
		MUL_HI_LO,
		MUL_LO_HI
	} mul_step_t;

	typedef struct packed {
		logic      clear_wr;
		logic      seed_load;
		logic      seed_store;
		logic      mul_en;
		mul_step_t mul_step;
		logic      regen_rd;
		logic      regen_wr;
		logic      next_rd;
		logic      next_out;
	} dp_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic seed_last;
		logic pool_empty;
		logic out_free;
	} dp_status_t;

endpackage

// ===== rtl/dptr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dptr_ctrl: sequencer of the twister rng
// walks the clearing pass, seeding chain, regeneration and word reads
// ----------------------------------------------------------------------------
module dptr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_is_seed,
	output logic                  in_ready,
	output dptr_pkg::dp_cmd_t     cmd,
	input  dptr_pkg::dp_status_t  status
);
	import dptr_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEED_STORE,
		ST_SEED_M0,
		ST_SEED_M1,
		ST_SEED_M2,
		ST_REGEN_RD,
		ST_REGEN_WR,
		ST_NEXT_RD,
		ST_NEXT_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_ready && in_valid;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.idx_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (in_is_seed) begin
						cmd.seed_load = 1'b1;
						state_d       = ST_SEED_STORE;
					end else if (status.pool_empty) begin
						state_d = ST_REGEN_RD;
					end else begin
						state_d = ST_NEXT_RD;
					end
				end
			end
			ST_SEED_STORE: begin
				cmd.seed_store = 1'b1;
				state_d = status.seed_last ? ST_IDLE : ST_SEED_M0;
			end
			ST_SEED_M0: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = MUL_LO_LO;
				state_d      = ST_SEED_M1;
			end
			ST_SEED_M1: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = MUL_HI_LO;
				state_d      = ST_SEED_M2;
			end
			ST_SEED_M2: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = MUL_LO_HI;
				state_d      = ST_SEED_STORE;
			end
			ST_REGEN_RD: begin
				cmd.regen_rd = 1'b1;
				state_d      = ST_REGEN_WR;
			end
			ST_REGEN_WR: begin
				cmd.regen_wr = 1'b1;
				state_d = status.idx_last ? ST_NEXT_RD : ST_REGEN_RD;
			end
			ST_NEXT_RD: begin
				cmd.next_rd = 1'b1;
				state_d     = ST_NEXT_OUT;
			end
			ST_NEXT_OUT: begin
				if (status.out_free) begin
					cmd.next_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/dptr_datapath.sv =====
// ----------------------------------------------------------------------------
// dptr_datapath: pool memory, lung, seeding multiplier and output register
// one write and two read ports on the pool, shared 32x32 multiplier
// ----------------------------------------------------------------------------
module dptr_datapath #(
	parameter int POOL_ENTRIES = dptr_pkg::POOL_ENTRIES_DEF,
	parameter int LEFT_SHIFT   = dptr_pkg::LEFT_SHIFT_DEF,
	parameter int PICK_OFFSET  = dptr_pkg::PICK_OFFSET_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dptr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [dptr_pkg::WORD_W-1:0]        cfg_data,
	input  logic [dptr_pkg::WORD_W-1:0]        seed,
	input  dptr_pkg::dp_cmd_t                  cmd,
	output dptr_pkg::dp_status_t               status,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [dptr_pkg::WORD_W-1:0]        out_data
);
	import dptr_pkg::*;

	localparam int IDX_W  = $clog2(POOL_ENTRIES);
	localparam int RPOS_W = $clog2(2 * POOL_ENTRIES + 1);
	localparam int WI_W   = $clog2(2 * POOL_ENTRIES + 2);
	localparam int SH     = LEFT_SHIFT % 64;
	localparam int OFF    = PICK_OFFSET % POOL_ENTRIES;

	localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(POOL_ENTRIES - 1);
	localparam logic [IDX_W:0]    IDX_N     = (IDX_W + 1)'(POOL_ENTRIES);
	localparam logic [IDX_W:0]    IDX_OFF   = (IDX_W + 1)'(OFF);
	localparam logic [RPOS_W-1:0] RPOS_FULL = RPOS_W'(2 * POOL_ENTRIES);
	localparam logic [WI_W-1:0]   WI_POOL   = WI_W'(2 * POOL_ENTRIES);
	localparam logic [WI_W-1:0]   WI_LAST   = WI_W'(2 * POOL_ENTRIES + 1);
	localparam logic [31:0]       MULT_LO   = SEED_MULT[31:0];
	localparam logic [31:0]       MULT_HI   = SEED_MULT[63:32];

	// configuration registers
	logic [WORD_W-1:0] mask_lo_q, mask_hi_q, mant_mask_q, exp_bits_q;

	// control state
	logic [IDX_W-1:0]   idx_q;
	logic [RPOS_W-1:0]  rpos_q;
	logic [WI_W-1:0]    wi_q;
	logic [ENTRY_W-1:0] lung_q;
	logic               out_valid_q;

	// payload
	logic [ENTRY_W-1:0] pool_mem [POOL_ENTRIES];
	logic [ENTRY_W-1:0] ra_q, rb_q;
	logic [WORD_W-1:0]  w_q, lo_q, op_q, acc_q, out_data_q;

	// pool port signals
	logic               mem_we;
	logic [IDX_W-1:0]   mem_wa;
	logic [ENTRY_W-1:0] mem_wd;
	logic [IDX_W-1:0]   rd_addr_a, rd_addr_b;
	logic [IDX_W:0]     pick_sum;

	// regeneration
	logic [WORD_W-1:0]  a0, a1, b0, b1, n0, n1;
	logic [ENTRY_W-1:0] regen_entry;

	// seeding
	logic [31:0]       mul_a, mul_b;
	logic [63:0]       prod;
	logic [63:0]       chain_x;
	logic              wi_in_pool;

	assign wi_in_pool = (wi_q < WI_POOL);

	// partner entry of the recursion, index wraps once at most
	assign pick_sum  = {1'b0, idx_q} + IDX_OFF;
	assign rd_addr_b = (pick_sum >= IDX_N) ? IDX_W'(pick_sum - IDX_N) : pick_sum[IDX_W-1:0];
	assign rd_addr_a = cmd.regen_rd ? idx_q : IDX_W'(rpos_q >> 1);

	assign a0 = ra_q[WORD_W-1:0];
	assign a1 = ra_q[ENTRY_W-1:WORD_W];
	assign b0 = rb_q[WORD_W-1:0];
	assign b1 = rb_q[ENTRY_W-1:WORD_W];

	function automatic logic [WORD_W-1:0] rot32(input logic [WORD_W-1:0] x);
		rot32 = {x[LUNG_ROT-1:0], x[WORD_W-1:LUNG_ROT]};
	endfunction

	assign n0 = (a0 << SH) ^ rot32(lung_q[ENTRY_W-1:WORD_W]) ^ b0;
	assign n1 = (a1 << SH) ^ rot32(lung_q[WORD_W-1:0]) ^ b1;
	assign regen_entry = {(n1 >> TEMPER_SHIFT) ^ (n1 & mask_hi_q) ^ a1,
	                      (n0 >> TEMPER_SHIFT) ^ (n0 & mask_lo_q) ^ a0};

	// one 32x32 partial product per cycle
	assign mul_a   = (cmd.mul_step == MUL_HI_LO) ? op_q[63:32] : op_q[31:0];
	assign mul_b   = (cmd.mul_step == MUL_LO_HI) ? MULT_HI : MULT_LO;
	assign prod    = {32'd0, mul_a} * {32'd0, mul_b};
	assign chain_x = {acc_q[63:32] + prod[31:0], acc_q[31:0]};

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = regen_entry;
		priority if (cmd.clear_wr) begin
			mem_we = 1'b1;
			mem_wd = '0;
		end else if (cmd.seed_store && wi_in_pool && wi_q[0]) begin
			mem_we = 1'b1;
			mem_wa = IDX_W'(wi_q >> 1);
			mem_wd = {w_q, lo_q};
		end else if (cmd.regen_wr) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) pool_mem[mem_wa] <= mem_wd;
		if (cmd.regen_rd || cmd.next_rd) ra_q <= pool_mem[rd_addr_a];
		if (cmd.regen_rd) rb_q <= pool_mem[rd_addr_b];
	end

	// seeding payload and output word
	always_ff @(posedge clk) begin
		if (cmd.seed_load) w_q <= (seed & mant_mask_q) | exp_bits_q;
		if (cmd.seed_store) begin
			op_q <= w_q ^ (w_q >> CHAIN_SHIFT);
			if (wi_in_pool && !wi_q[0]) lo_q <= w_q;
		end
		if (cmd.mul_en) begin
			unique case (cmd.mul_step)
				MUL_LO_LO: acc_q <= prod + 64'(wi_q);
				MUL_HI_LO: acc_q[63:32] <= acc_q[63:32] + prod[31:0];
				MUL_LO_HI: w_q <= wi_in_pool ? ((chain_x & mant_mask_q) | exp_bits_q)
				                             : chain_x;
				default: acc_q <= acc_q;
			endcase
		end
		if (cmd.next_out) out_data_q <= rpos_q[0] ? a1 : a0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_lo_q   <= MASK_LO_RST;
			mask_hi_q   <= MASK_HI_RST;
			mant_mask_q <= MANT_MASK_RST;
			exp_bits_q  <= EXP_BITS_RST;
			idx_q       <= '0;
			rpos_q      <= '0;
			wi_q        <= '0;
			lung_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_MASK_LO:   mask_lo_q   <= cfg_data;
					CFG_MASK_HI:   mask_hi_q   <= cfg_data;
					CFG_MANT_MASK: mant_mask_q <= cfg_data;
					CFG_EXP_BITS:  exp_bits_q  <= cfg_data;
					default:       mask_lo_q   <= mask_lo_q;
				endcase
			end
			if (cmd.clear_wr || cmd.regen_wr) begin
				idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
			end
			if (cmd.regen_wr) begin
				lung_q <= {n1, n0};
				if (idx_q == IDX_LAST) rpos_q <= '0;
			end
			if (cmd.seed_load) wi_q <= '0;
			if (cmd.seed_store) begin
				wi_q <= wi_q + 1'b1;
				if (wi_q == WI_POOL) lung_q[WORD_W-1:0] <= w_q;
				if (wi_q == WI_LAST) begin
					lung_q[ENTRY_W-1:WORD_W] <= w_q;
					rpos_q <= RPOS_FULL;
				end
			end
			if (cmd.next_out) begin
				rpos_q      <= rpos_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.idx_last   = (idx_q == IDX_LAST);
	assign status.seed_last  = (wi_q == WI_LAST);
	assign status.pool_empty = (rpos_q >= RPOS_FULL);
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== rtl/double_precision_twister_rng_unit.sv =====
// next: a transfer steps through ST_NEXT_RD and ST_NEXT_OUT before its word shows on
//   m_tvalid; ST_NEXT_OUT waits while the output register holds an untaken word
// when the pool is empty (every 2*POOL_ENTRIES numbers) it is regenerated first, entry
//   by entry, read and write in separate states; a transfer is taken only in ST_IDLE
// a seed stores each word, then forms the next on one shared 32x32 multiplier
// reset: after arst_n releases, a clearing pass writes zeros to every entry of the pool
// ----------------------------------------------------------------------------
// double_precision_twister_rng_unit: double precision twister random source
// scalar recursion over a 128-bit entry pool, words returned as doubles in [1,2)
// ----------------------------------------------------------------------------
module double_precision_twister_rng_unit #(
	parameter int POOL_ENTRIES = dptr_pkg::POOL_ENTRIES_DEF,
	parameter int LEFT_SHIFT   = dptr_pkg::LEFT_SHIFT_DEF,
	parameter int PICK_OFFSET  = dptr_pkg::PICK_OFFSET_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// command stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [dptr_pkg::WORD_W-1:0]       s_tdata,   // [63:0] seed
	input  logic                              s_tuser,   // [0] cmd: 1 seed, 0 next
	// number stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [dptr_pkg::WORD_W-1:0]       m_tdata,   // [63:0] value
	// register writes
	input  logic                              cfg_we,
	input  logic [dptr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [dptr_pkg::WORD_W-1:0]       cfg_data
);
	import dptr_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	// sequencer: owns the handshake on the command stream, one transfer at a time
	dptr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_is_seed (s_tuser),
		.in_ready   (s_tready),
		.cmd        (dp_cmd),
		.status     (dp_status)
	);

	// datapath: pool memory, lung, seeding chain and the output register,
	// which holds a finished word while the next transfer is taken in
	dptr_datapath #(
		.POOL_ENTRIES (POOL_ENTRIES),
		.LEFT_SHIFT   (LEFT_SHIFT),
		.PICK_OFFSET  (PICK_OFFSET)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.seed      (s_tdata),
		.cmd       (dp_cmd),
		.status    (dp_status),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

endmodule

// ===== rtl/dptr_checker.sv =====
// ----------------------------------------------------------------------------
// dptr_checker: port-level checks of the twister rng
// bound to the top level
// ----------------------------------------------------------------------------
module dptr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [dptr_pkg::WORD_W-1:0]       m_tdata
);

	// no commands taken during reset or on the first cycle of the clearing pass
	a_clear_busy: assert property (@(posedge clk)
		(!arst_n || $rose(arst_n)) |-> !s_tready)
		else $error("command taken before the pool was cleared");

	// every transfer keeps the unit busy on the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("command stream ready right after a transfer");

	// a seed never produces a number
	a_seed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser && !m_tvalid) |=> !m_tvalid)
		else $error("number produced by a seed command");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("number withdrawn before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("stalled number changed");

endmodule

bind double_precision_twister_rng_unit dptr_checker u_dptr_checker (.*);
